@@ rtl/btas_pkg.sv @@
// Shared types and constants for the block transfer address sequencer.
// No dependencies; imported by btas_ctrl, btas_dp and the top level.
package btas_pkg;

	localparam logic [1:0] ST_XFER    = 2'd0;
	localparam logic [1:0] ST_SKIP    = 2'd1;
	localparam logic [1:0] ST_INVALID = 2'd2;

	localparam logic [3:0] PC_REG = 4'd15;

	localparam int P_BIT = 24;
	localparam int U_BIT = 23;
	localparam int W_BIT = 21;
	localparam int L_BIT = 20;
	localparam int RN_LO = 16;

	typedef struct packed {
		logic [31:0] instr_word;
		logic [31:0] base_value;
		logic        cond_passed;
	} btas_in_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] word_address;
		logic [3:0]  reg_index;
		logic        is_load;
		logic        last;
		logic        wb_enable;
		logic [31:0] wb_value;
		logic [3:0]  wb_reg;
	} btas_out_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic step;
	} btas_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic last;
	} btas_sts_t;

endpackage

@@ rtl/block_transfer_address_sequencer.sv @@
// Block transfer address sequencer: the first result is registered in run; one
// result per cycle after that, so an instruction with N listed registers holds
// busy for N results (one for skipped or invalid) and the next start is taken
// the cycle busy falls. The run length is set by the remaining-list register
// that the datapath clears one bit per cycle. Reset clears the controller and
// the result strobe; the receiver cannot stall.
module block_transfer_address_sequencer #(
	parameter int NUM_REGS   = 16,
	parameter int WORD_BYTES = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  btas_pkg::btas_in_t  item,
	output logic                strobe,
	output btas_pkg::btas_out_t result
);
	import btas_pkg::*;

	btas_cmd_t cmd;
	btas_sts_t sts;

	btas_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.sts    (sts)
	);

	btas_dp #(
		.NUM_REGS   (NUM_REGS),
		.WORD_BYTES (WORD_BYTES)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.sts    (sts),
		.strobe (strobe),
		.result (result)
	);

endmodule

@@ rtl/btas_ctrl.sv @@
// Controller state machine for the block transfer address sequencer.
// Depends on btas_pkg for the command and status structs.
module btas_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	output btas_pkg::btas_cmd_t cmd,
	input  btas_pkg::btas_sts_t sts
);
	import btas_pkg::*;

	localparam logic S_IDLE = 1'b0;
	localparam logic S_RUN  = 1'b1;

	logic state_q;
	logic state_d;

	assign busy = (state_q == S_RUN);

	always_comb begin
		state_d  = state_q;
		cmd.load = 1'b0;
		cmd.step = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_RUN;
				end
			end
			S_RUN: begin
				cmd.step = 1'b1;
				if (sts.last) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_load_runs: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == S_RUN)
		else $error("load did not start a run");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && sts.last) |=> state_q == S_IDLE)
		else $error("run did not end on last transfer");

	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !cmd.load)
		else $error("load while busy");

endmodule

@@ rtl/btas_dp.sv @@
// Datapath: instruction fields, remaining register list, running address and
// the registered result. Depends on btas_pkg.
module btas_dp #(
	parameter int NUM_REGS   = 16,
	parameter int WORD_BYTES = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  btas_pkg::btas_in_t  item,
	input  btas_pkg::btas_cmd_t cmd,
	output btas_pkg::btas_sts_t sts,
	output logic                strobe,
	output btas_pkg::btas_out_t result
);
	import btas_pkg::*;

	localparam int RW = $clog2(NUM_REGS);
	localparam logic [31:0] STEP = 32'(WORD_BYTES);

	logic [1:0]          mode_q;
	logic [NUM_REGS-1:0] list_q;
	logic [31:0]         addr_q;
	logic                p_q, u_q, w_q, l_q;
	logic [3:0]          rn_q;
	btas_out_t           result_q;
	logic                strobe_q;

	logic [NUM_REGS-1:0] in_list;
	logic [3:0]          in_rn;
	logic [RW-1:0]       sel_idx;
	logic [NUM_REGS-1:0] sel_oh;
	logic [NUM_REGS-1:0] rest;
	logic                fin;
	logic [31:0]         nxt;
	logic [31:0]         here;
	btas_out_t           result_d;

	assign in_list = item.instr_word[NUM_REGS-1:0];
	assign in_rn   = item.instr_word[RN_LO+3:RN_LO];

	// Up mode takes the lowest remaining register, down mode the highest.
	always_comb begin
		sel_idx = '0;
		if (u_q) begin
			for (int i = NUM_REGS - 1; i >= 0; i--) begin
				if (list_q[i]) sel_idx = RW'(i);
			end
		end else begin
			for (int i = 0; i < NUM_REGS; i++) begin
				if (list_q[i]) sel_idx = RW'(i);
			end
		end
		sel_oh          = '0;
		sel_oh[sel_idx] = 1'b1;
	end

	assign rest = list_q & ~sel_oh;
	assign fin  = (rest == '0);
	assign nxt  = u_q ? addr_q + STEP : addr_q - STEP;
	assign here = p_q ? nxt : addr_q;

	assign sts.last = (mode_q != ST_XFER) || fin;

	always_comb begin
		result_d        = '0;
		result_d.status = mode_q;
		result_d.last   = 1'b1;
		if (mode_q == ST_XFER) begin
			result_d.word_address = here;
			result_d.reg_index    = 4'(sel_idx);
			result_d.is_load      = l_q;
			result_d.last         = fin;
			if (fin) begin
				result_d.wb_enable = w_q;
				result_d.wb_value  = nxt;
				result_d.wb_reg    = rn_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			p_q    <= item.instr_word[P_BIT];
			u_q    <= item.instr_word[U_BIT];
			w_q    <= item.instr_word[W_BIT];
			l_q    <= item.instr_word[L_BIT];
			rn_q   <= in_rn;
			list_q <= in_list;
			addr_q <= item.base_value;
			if (!item.cond_passed) begin
				mode_q <= ST_SKIP;
			end else if (in_rn == PC_REG || in_list == '0) begin
				mode_q <= ST_INVALID;
			end else begin
				mode_q <= ST_XFER;
			end
		end else if (cmd.step) begin
			list_q   <= rest;
			addr_q   <= nxt;
			result_q <= result_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.step;
		end
	end

	assign strobe = strobe_q;
	assign result = result_q;

	a_strobe_from_step: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(cmd.step))
		else $error("result strobe without a step");

	a_non_xfer_last: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && result.status != ST_XFER) |-> (result.last && result.wb_enable == 1'b0))
		else $error("skipped or invalid result not marked last");

	a_wb_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !result.last) |-> (result.wb_enable == 1'b0 && result.wb_value == '0))
		else $error("writeback on a non-final transfer");

endmodule

@@ tb/sv/block_transfer_address_sequencer_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for block_transfer_address_sequencer: a directed table, then shaped
// random instructions, each checked transfer by transfer against a local address predictor.
// Depends on btas_pkg and the RTL of the block only.
module block_transfer_address_sequencer_tb;
	import btas_pkg::*;

	localparam int NREGS      = 16;
	localparam int STEP_BYTES = 4;
	localparam int RAND_INSTRS = 260;
	localparam int CYCLE_LIMIT = 60000;

	typedef struct {
		btas_in_t  stim;
		bit        typed;
		btas_out_t want;
	} dir_row_t;

	logic      clk;
	logic      arst_n;
	logic      start;
	logic      busy;
	btas_in_t  item;
	logic      strobe;
	btas_out_t result;

	btas_out_t due_xfers[$];
	dir_row_t  dir_rows[$];
	int        n_errors;
	int        n_instrs;
	int        n_xfers;
	int        n_skips;
	int        n_rejects;
	int        cycles;

	block_transfer_address_sequencer #(
		.NUM_REGS  (NREGS),
		.WORD_BYTES(STEP_BYTES)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.item  (item),
		.strobe(strobe),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("block_transfer_address_sequencer regression: fail");
			$finish;
		end
	end

	task automatic flag_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("[%0t] mismatch %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
		n_errors++;
	endtask

	function automatic logic [31:0] mk_instr(input bit p, input bit u, input bit w,
			input bit l, input logic [3:0] rn, input logic [15:0] list);
		logic [31:0] word;
		word = '0;
		word[P_BIT] = p;
		word[U_BIT] = u;
		word[W_BIT] = w;
		word[L_BIT] = l;
		word[RN_LO +: 4] = rn;
		word[15:0] = list;
		return word;
	endfunction

	// Expected transfers for one instruction, in issue order.
	function automatic void plan_transfers(input btas_in_t it);
		logic [31:0] addr;
		logic [31:0] here;
		logic [15:0] list;
		logic [3:0]  rn;
		logic [3:0]  r;
		logic        p, u;
		int          left;
		btas_out_t   o;
		p    = it.instr_word[P_BIT];
		u    = it.instr_word[U_BIT];
		rn   = it.instr_word[RN_LO +: 4];
		list = it.instr_word[15:0];
		for (int b = NREGS; b < 16; b++)
			list[b] = 1'b0;
		o = '0;
		o.last = 1'b1;
		if (!it.cond_passed) begin
			o.status = ST_SKIP;
			due_xfers.push_back(o);
			return;
		end
		if (rn == PC_REG || list == '0) begin
			o.status = ST_INVALID;
			due_xfers.push_back(o);
			return;
		end
		left = $countones(list);
		addr = it.base_value;
		// decrement modes walk from the top so the lowest register gets the lowest address
		for (int i = 0; i < NREGS; i++) begin
			r = u ? 4'(i) : 4'(NREGS - 1 - i);
			if (list[r]) begin
				if (p)
					addr = u ? addr + 32'(STEP_BYTES) : addr - 32'(STEP_BYTES);
				here = addr;
				if (!p)
					addr = u ? addr + 32'(STEP_BYTES) : addr - 32'(STEP_BYTES);
				left--;
				o = '0;
				o.status       = ST_XFER;
				o.word_address = here;
				o.reg_index    = r;
				o.is_load      = it.instr_word[L_BIT];
				if (left == 0) begin
					o.last      = 1'b1;
					o.wb_enable = it.instr_word[W_BIT];
					o.wb_value  = addr;
					o.wb_reg    = rn;
				end
				due_xfers.push_back(o);
			end
		end
	endfunction

	// Result monitor: strobe and result are sampled as they stood before the edge.
	always @(posedge clk) begin : result_check
		btas_out_t want;
		if (arst_n && strobe) begin
			case (result.status)
				ST_XFER: n_xfers++;
				ST_SKIP: n_skips++;
				default: n_rejects++;
			endcase
			if (due_xfers.size() == 0) begin
				flag_mismatch("result with none due, status", 32'(result.status), '0);
			end else begin
				want = due_xfers.pop_front();
				if (result.status !== want.status)
					flag_mismatch("status", 32'(result.status), 32'(want.status));
				if (result.word_address !== want.word_address)
					flag_mismatch("word_address", result.word_address, want.word_address);
				if (result.reg_index !== want.reg_index)
					flag_mismatch("reg_index", 32'(result.reg_index), 32'(want.reg_index));
				if (result.is_load !== want.is_load)
					flag_mismatch("is_load", 32'(result.is_load), 32'(want.is_load));
				if (result.last !== want.last)
					flag_mismatch("last", 32'(result.last), 32'(want.last));
				if (result.wb_enable !== want.wb_enable)
					flag_mismatch("wb_enable", 32'(result.wb_enable), 32'(want.wb_enable));
				if (result.wb_value !== want.wb_value)
					flag_mismatch("wb_value", result.wb_value, want.wb_value);
				if (result.wb_reg !== want.wb_reg)
					flag_mismatch("wb_reg", 32'(result.wb_reg), 32'(want.wb_reg));
			end
		end
	end

	// One instruction transfer; start is left high so back-to-back issue needs no re-raise.
	task automatic issue_instr(input btas_in_t it, input bit typed, input btas_out_t want,
			input bit may_idle);
		int gap;
		if (may_idle && $urandom_range(0, 99) < 11) begin
			gap = $urandom_range(1, 5);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		item  <= it;
		do
			@(posedge clk);
		while (busy);
		n_instrs++;
		if (typed)
			due_xfers.push_back(want);
		else
			plan_transfers(it);
	endtask

	task automatic add_row(input logic [31:0] instr, input logic [31:0] base, input bit cond,
			input bit typed, input logic [1:0] status);
		dir_row_t row;
		row.stim.instr_word  = instr;
		row.stim.base_value  = base;
		row.stim.cond_passed = cond;
		row.typed            = typed;
		row.want             = '0;
		row.want.status      = status;
		row.want.last        = 1'b1;
		dir_rows.push_back(row);
	endtask

	initial begin : stimulus
		btas_in_t    it;
		btas_out_t   none;
		logic [15:0] list;
		int          kind;
		int          sel;
		none      = '0;
		n_instrs  = 0;
		arst_n <= 1'b0;
		start  <= 1'b0;
		item   <= '0;

		// condition failure wins over every other case
		add_row(mk_instr(1, 1, 1, 1, 4'd3, 16'hFFFF), 32'h0000_1000, 1'b0, 1'b1, ST_SKIP);
		add_row(32'hFFFF_0000, 32'hFFFF_FFFF, 1'b0, 1'b1, ST_SKIP);
		// base r15 and empty list are rejected
		add_row(mk_instr(0, 1, 1, 0, PC_REG, 16'hFFFF), 32'h0000_2000, 1'b1, 1'b1, ST_INVALID);
		add_row(mk_instr(1, 0, 1, 1, 4'd0, 16'h0000), 32'h0000_3000, 1'b1, 1'b1, ST_INVALID);
		add_row(32'hFFF0_0000, 32'hFFFF_FFFF, 1'b1, 1'b1, ST_INVALID);
		// all four address modes with a full list, writeback and direction both ways
		for (int m = 0; m < 8; m++)
			add_row(mk_instr(m[1], m[0], m[2], ~m[2], 4'(m + 1), 16'hFFFF),
				32'h8000_0000, 1'b1, 1'b0, ST_XFER);
		add_row(mk_instr(0, 1, 1, 1, 4'd14, 16'h0001), 32'h0000_0000, 1'b1, 1'b0, ST_XFER);
		// wrap below zero and above the top of the address space
		add_row(mk_instr(1, 0, 1, 0, 4'd13, 16'h8000), 32'h0000_0000, 1'b1, 1'b0, ST_XFER);
		add_row(mk_instr(1, 1, 1, 1, 4'd0, 16'hFFFF), 32'hFFFF_FFF0, 1'b1, 1'b0, ST_XFER);
		add_row(mk_instr(0, 0, 1, 0, 4'd5, 16'h8001), 32'h0000_0000, 1'b1, 1'b0, ST_XFER);
		add_row(32'hFFFE_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, ST_XFER);
		// ignored instruction bits set
		add_row(32'hFE40_0000 | mk_instr(0, 0, 0, 0, 4'd2, 16'h5555), 32'h0, 1'b1, 1'b0,
			ST_XFER);
		add_row(mk_instr(0, 1, 0, 1, 4'd7, 16'hAAAA), 32'h1234_5678, 1'b1, 1'b0, ST_XFER);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[k])
			issue_instr(dir_rows[k].stim, dir_rows[k].typed, dir_rows[k].want, 1'b1);

		for (int n = 0; n < RAND_INSTRS; n++) begin
			kind = $urandom_range(0, 99);
			it.instr_word  = $urandom;
			it.base_value  = $urandom;
			it.cond_passed = 1'b1;
			if (kind < 10)
				it.base_value = 32'hFFFF_FFE0 | ($urandom & 32'h1F);
			else if (kind < 20)
				it.base_value = $urandom & 32'h3F;
			if (kind < 85) begin
				// well-formed instruction with random content
				sel = $urandom_range(0, 9);
				if (sel < 3)
					list = 16'h0001 << $urandom_range(0, 15);
				else if (sel == 3)
					list = 16'hFFFF;
				else
					list = 16'($urandom);
				if (list == '0)
					list = 16'h0100;
				it.instr_word[RN_LO +: 4] = 4'($urandom_range(0, 14));
				it.instr_word[15:0]       = list;
			end else begin
				it.cond_passed = 1'($urandom_range(0, 1));
				sel = $urandom_range(0, 2);
				if (sel == 0)
					it.instr_word[15:0] = '0;
				else if (sel == 1)
					it.instr_word[RN_LO +: 4] = PC_REG;
			end
			// one long stretch with the sender never pausing
			issue_instr(it, 1'b0, none, !(n >= 100 && n < 180));
		end
		start <= 1'b0;

		while (due_xfers.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("%0d instructions issued: %0d transfers, %0d skipped, %0d rejected",
			n_instrs, n_xfers, n_skips, n_rejects);
		$display("all four address modes, address wrap and ignored word bits exercised");
		if (n_errors == 0)
			$display("block_transfer_address_sequencer regression: pass");
		else
			$display("block_transfer_address_sequencer regression: fail");
		$finish;
	end

endmodule
